>>> src/grb_pkg.sv
// shared types and constants of the glyph bitmap renderer
`timescale 1ns / 1ps

package grb_pkg;

    localparam int GRB_QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_SIZE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FONT_BASE_24    = 2'd1;

    localparam logic [7:0]  CODE_FIRST     = 8'hA1;
    localparam logic [13:0] CODES_PER_ZONE = 14'd94;
    localparam logic [7:0]  BYTES_32       = 8'd128;
    localparam logic [7:0]  BYTES_24       = 8'd72;
    localparam logic [15:0] WIDTH_32       = 16'd32;
    localparam logic [15:0] WIDTH_24       = 16'd24;
    localparam logic [15:0] ADVANCE_32     = 16'd32;
    localparam logic [15:0] ADVANCE_24     = 16'd20;
    localparam logic [15:0] BYTE_PIXELS    = 16'd8;

    typedef enum logic [1:0] {
        CMD_SET_PEN   = 2'd0,
        CMD_CHAR      = 2'd1,
        CMD_FONT_BYTE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        KIND_FETCH = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    // one queued job: a single result, or one font byte to expand
    typedef struct packed {
        kind_t       kind;
        logic [23:0] flash_address;
        logic [7:0]  fetch_length;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] pixel_colour;
        logic [7:0]  bits;
    } grb_job_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] flash_address;
        logic [7:0]  fetch_length;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] pixel_colour;
        logic        last;
    } grb_result_t;

endpackage

>>> src/grb_if.sv
// channel interfaces of the glyph bitmap renderer
`timescale 1ns / 1ps

interface grb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] pen_x_in;
    logic [15:0] pen_y_in;
    logic [15:0] colour_in;
    logic [7:0]  code_high;
    logic [7:0]  code_low;
    logic [7:0]  font_byte;

    modport source (output valid, command, pen_x_in, pen_y_in, colour_in,
                     code_high, code_low, font_byte, input ready);
    modport sink   (input valid, command, pen_x_in, pen_y_in, colour_in,
                     code_high, code_low, font_byte, output ready);
endinterface

interface grb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [23:0] flash_address;
    logic [7:0]  fetch_length;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pixel_colour;
    logic        last;

    modport source (output valid, kind, flash_address, fetch_length, pixel_x,
                     pixel_y, pixel_colour, last, input ready);
    modport sink   (input valid, kind, flash_address, fetch_length, pixel_x,
                     pixel_y, pixel_colour, last, output ready);
endinterface

interface grb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/glyph_bitmap_renderer_core.sv
// top level of the glyph bitmap renderer
`timescale 1ns / 1ps

// Glyph bitmap renderer for GB2312 text. A set-pen item loads the pen and the
// colour and yields nothing. A character item yields one item: a flash fetch
// request for the glyph bitmap (128 bytes for 32x32, 72 bytes at font_base_24
// for 24x24) or a bad-code item when either byte is below 0xA1; a good code
// advances the pen by 32 or 20. Each font byte then yields one pixel write per
// set bit, LSB first, wrapping rows at the glyph width. Input items are taken
// every cycle while the job queue has room; the front end settles all pen and
// cursor state at accept time. The back end drains the queue at one result per
// cycle while the output is taken, so a font byte gives as many results as it
// has set bits (one to eight), a character item one, and a blank or stray byte
// none. The output register lets the next result form while one waits.

module glyph_bitmap_renderer_core
    import grb_pkg::*;
#(
    parameter int QUEUE_DEPTH = GRB_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    grb_in_if.sink    item_in,
    grb_cfg_if.sink   cfg,
    grb_out_if.source result_out
);

    // front to queue
    logic     push_valid;
    logic     push_ready;
    grb_job_t push_data;

    // queue to back
    logic     pop_valid;
    logic     pop_ready;
    grb_job_t pop_data;

    // classifies items and keeps pen, colour and glyph cursor
    grb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short job queue so either side can stall on its own
    grb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // one result per cycle while the output is taken, towards the display and flash side
    grb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .result_out (result_out)
    );

endmodule

>>> src/grb_front.sv
// front end: config registers, pen and glyph state, job classification
`timescale 1ns / 1ps

module grb_front
    import grb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    grb_in_if.sink        item_in,
    grb_cfg_if.sink       cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output grb_job_t      push_data
);

    logic        glyph_size_mode_reg, glyph_size_mode_next;
    logic [23:0] font_base_24_reg, font_base_24_next;
    logic [15:0] pen_x_reg, pen_x_next;
    logic [15:0] pen_y_reg, pen_y_next;
    logic [15:0] draw_colour_reg, draw_colour_next;
    logic [15:0] glyph_left_reg, glyph_left_next;
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;

    logic        accept;
    command_t    cmd;
    logic [7:0]  hi_off;
    logic [7:0]  lo_off;
    logic [13:0] glyph_index;
    logic [23:0] index_24;
    logic [23:0] addr;
    logic [7:0]  len;
    logic [15:0] row_width;
    logic [15:0] next_x;
    logic [15:0] row_offset;

    assign item_in.ready = push_ready;
    assign cfg.ready     = 1'b1;
    assign accept        = item_in.valid && push_ready;
    assign cmd           = command_t'(item_in.command);

    // glyph index and flash address
    assign hi_off      = item_in.code_high - CODE_FIRST;
    assign lo_off      = item_in.code_low - CODE_FIRST;
    assign glyph_index = 14'(hi_off[6:0]) * CODES_PER_ZONE + 14'(lo_off[6:0]);
    assign index_24    = 24'(glyph_index);
    assign addr        = glyph_size_mode_reg
                         ? font_base_24_reg + (index_24 << 6) + (index_24 << 3)
                         : index_24 << 7;
    assign len         = glyph_size_mode_reg ? BYTES_24 : BYTES_32;

    // row wrap after a whole byte of pixels
    assign row_width  = glyph_size_mode_reg ? WIDTH_24 : WIDTH_32;
    assign next_x     = cursor_x_reg + BYTE_PIXELS;
    assign row_offset = next_x - glyph_left_reg;

    always_comb
    begin
        glyph_size_mode_next = glyph_size_mode_reg;
        font_base_24_next    = font_base_24_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GLYPH_SIZE_MODE: glyph_size_mode_next = cfg.data[0];
                CFG_FONT_BASE_24:    font_base_24_next    = cfg.data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        pen_x_next       = pen_x_reg;
        pen_y_next       = pen_y_reg;
        draw_colour_next = draw_colour_reg;
        glyph_left_next  = glyph_left_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        bytes_left_next  = bytes_left_reg;
        push_valid       = 1'b0;
        push_data        = '0;
        push_data.kind   = KIND_FETCH;
        if (accept)
        begin
            case (cmd)
                CMD_SET_PEN:
                begin
                    pen_x_next       = item_in.pen_x_in;
                    pen_y_next       = item_in.pen_y_in;
                    draw_colour_next = item_in.colour_in;
                end
                CMD_CHAR:
                begin
                    push_valid = 1'b1;
                    if (item_in.code_high < CODE_FIRST || item_in.code_low < CODE_FIRST)
                    begin
                        push_data.kind = KIND_BAD;
                    end
                    else
                    begin
                        push_data.flash_address = addr;
                        push_data.fetch_length  = len;
                        glyph_left_next = pen_x_reg;
                        cursor_x_next   = pen_x_reg;
                        cursor_y_next   = pen_y_reg;
                        bytes_left_next = len;
                        pen_x_next      = pen_x_reg
                                          + (glyph_size_mode_reg ? ADVANCE_24 : ADVANCE_32);
                    end
                end
                CMD_FONT_BYTE:
                begin
                    if (bytes_left_reg != 8'd0)
                    begin
                        push_valid             = item_in.font_byte != 8'd0;
                        push_data.kind         = KIND_PIXEL;
                        push_data.pixel_x      = cursor_x_reg;
                        push_data.pixel_y      = cursor_y_reg;
                        push_data.pixel_colour = draw_colour_reg;
                        push_data.bits         = item_in.font_byte;
                        bytes_left_next        = bytes_left_reg - 8'd1;
                        if (row_offset == row_width)
                        begin
                            cursor_x_next = glyph_left_reg;
                            cursor_y_next = cursor_y_reg + 16'd1;
                        end
                        else
                        begin
                            cursor_x_next = next_x;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_size_mode_reg <= 1'b0;
            font_base_24_reg    <= '0;
            pen_x_reg           <= '0;
            pen_y_reg           <= '0;
            draw_colour_reg     <= '0;
            glyph_left_reg      <= '0;
            cursor_x_reg        <= '0;
            cursor_y_reg        <= '0;
            bytes_left_reg      <= '0;
        end
        else
        begin
            glyph_size_mode_reg <= glyph_size_mode_next;
            font_base_24_reg    <= font_base_24_next;
            pen_x_reg           <= pen_x_next;
            pen_y_reg           <= pen_y_next;
            draw_colour_reg     <= draw_colour_next;
            glyph_left_reg      <= glyph_left_next;
            cursor_x_reg        <= cursor_x_next;
            cursor_y_reg        <= cursor_y_next;
            bytes_left_reg      <= bytes_left_next;
        end
    end

endmodule

>>> src/grb_queue.sv
// job queue between front and back end
`timescale 1ns / 1ps

module grb_queue
    import grb_pkg::*;
#(
    parameter int DEPTH = GRB_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  grb_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output grb_job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    grb_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/grb_back.sv
// back end: expands jobs into results, one per cycle while the output is taken, into an output register
`timescale 1ns / 1ps

module grb_back
    import grb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  grb_job_t  pop_data,
    grb_out_if.source result_out
);

    logic        work_valid_reg, work_valid_next;
    grb_job_t    work_reg;
    logic [7:0]  mask_reg, mask_next;
    logic        out_valid_reg, out_valid_next;
    grb_result_t out_reg;

    logic        can_emit;
    logic        emit;
    logic [2:0]  bit_pos;
    logic [7:0]  mask_rest;
    logic        job_done;
    logic        load_work;
    grb_result_t result;

    assign can_emit  = !out_valid_reg || result_out.ready;
    assign emit      = work_valid_reg && can_emit;

    // lowest set bit is the leftmost pixel still to draw
    always_comb
    begin
        bit_pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                bit_pos = 3'(i);
            end
        end
    end

    assign mask_rest = mask_reg & ~(8'b1 << bit_pos);
    assign job_done  = (work_reg.kind != KIND_PIXEL) || (mask_rest == 8'd0);
    assign pop_ready = !work_valid_reg || (emit && job_done);
    assign load_work = pop_valid && pop_ready;

    always_comb
    begin
        result.kind          = work_reg.kind;
        result.flash_address = work_reg.flash_address;
        result.fetch_length  = work_reg.fetch_length;
        result.pixel_x       = work_reg.pixel_x;
        result.pixel_y       = work_reg.pixel_y;
        result.pixel_colour  = work_reg.pixel_colour;
        result.last          = job_done;
        if (work_reg.kind == KIND_PIXEL)
        begin
            result.pixel_x = work_reg.pixel_x + 16'(bit_pos);
        end
    end

    always_comb
    begin
        work_valid_next = work_valid_reg;
        mask_next       = mask_reg;
        if (emit)
        begin
            mask_next = mask_rest;
            if (job_done)
            begin
                work_valid_next = 1'b0;
            end
        end
        if (load_work)
        begin
            work_valid_next = 1'b1;
            mask_next       = pop_data.bits;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (load_work)
        begin
            work_reg <= pop_data;
        end
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.kind          = out_reg.kind;
    assign result_out.flash_address = out_reg.flash_address;
    assign result_out.fetch_length  = out_reg.fetch_length;
    assign result_out.pixel_x       = out_reg.pixel_x;
    assign result_out.pixel_y       = out_reg.pixel_y;
    assign result_out.pixel_colour  = out_reg.pixel_colour;
    assign result_out.last          = out_reg.last;

endmodule

>>> bench/glyph_bitmap_renderer_core_tb.sv
// self-checking testbench of the glyph bitmap renderer core
`timescale 1ns / 1ps

module glyph_bitmap_renderer_core_tb;
    import grb_pkg::*;

    // the command value the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 30;     // items queued per random phase
    localparam int SETTLE_CYCLES    = 16;     // quiet cycles before a register write
    localparam int DRAIN_LIMIT      = 50000;  // cycles allowed for results to drain
    localparam int LONG_HOLD        = 300;    // receiver stall that fills the job queue
    localparam int MAX_REPORTS      = 20;

    // one input item as the sender sees it
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] pen_x;
        logic [15:0] pen_y;
        logic [15:0] colour;
        logic [7:0]  code_high;
        logic [7:0]  code_low;
        logic [7:0]  font_byte;
    } in_item_t;

    logic clk;
    logic rst_n;

    grb_in_if  item_if ();
    grb_cfg_if cfg_if ();
    grb_out_if res_if ();

    glyph_bitmap_renderer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .cfg        (cfg_if),
        .result_out (res_if)
    );

    // items waiting for the driver, and results the renderer still owes us
    in_item_t    feed_items[$];
    grb_result_t expected_draws[$];

    // predictor copy of the registers and of the pen and glyph state
    logic        size_24        = 1'b0;
    logic [23:0] table_base_24  = '0;
    logic [15:0] pen_col        = '0;
    logic [15:0] pen_row        = '0;
    logic [15:0] ink            = '0;
    logic [15:0] glyph_origin_x = '0;
    logic [15:0] draw_x         = '0;
    logic [15:0] draw_y         = '0;
    logic [7:0]  glyph_bytes_due = '0;

    // sender-side view of the glyph in progress, used to tell ignored items apart
    int plan_bytes_left = 0;
    int planned_work    = 0;
    int items_queued    = 0;

    // handshake bookkeeping
    bit       in_fire      = 1'b0;
    bit       gaps_on      = 1'b1;
    int       feed_gap     = 0;
    int       sink_hold    = 0;
    int       burst_asked  = 0;
    int       burst_served = 0;
    in_item_t feed_next;

    // run statistics
    int errors      = 0;
    int items_taken = 0;
    int fetch_seen  = 0;
    int pixel_seen  = 0;
    int bad_seen    = 0;
    int reg_writes  = 0;

    // clock and a single reset at the start of the run
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.command      = '0;
        item_if.pen_x_in     = '0;
        item_if.pen_y_in     = '0;
        item_if.colour_in    = '0;
        item_if.code_high    = '0;
        item_if.code_low     = '0;
        item_if.font_byte    = '0;
        res_if.ready         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("%0t: run timed out with %0d results outstanding", $time,
                 expected_draws.size());
        $display("Mismatches found");
        $finish;
    end

    // gap or stall length: mostly a few cycles, now and then a long one
    function automatic int pick_pause();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // predictor: works out the results of one accepted item
    // ------------------------------------------------------------------
    task automatic render_item(input in_item_t it);
        grb_result_t r;
        logic [31:0] glyph_index;
        logic [15:0] row_width;
        int          hits;
        r = '0;
        case (it.command)
            CMD_SET_PEN:
            begin
                // pen and colour load at once, even in the middle of a glyph
                pen_col = it.pen_x;
                pen_row = it.pen_y;
                ink     = it.colour;
            end
            CMD_CHAR:
            begin
                r.last = 1'b1;
                if (it.code_high < CODE_FIRST || it.code_low < CODE_FIRST)
                begin
                    // bad code: an error item, pen and glyph left alone
                    r.kind = KIND_BAD;
                end
                else
                begin
                    glyph_index = (32'(it.code_high) - 32'(CODE_FIRST)) * 32'(CODES_PER_ZONE)
                                + (32'(it.code_low) - 32'(CODE_FIRST));
                    r.kind = KIND_FETCH;
                    if (!size_24)
                    begin
                        r.fetch_length  = BYTES_32;
                        r.flash_address = 24'(glyph_index * 32'(BYTES_32));
                    end
                    else
                    begin
                        r.fetch_length  = BYTES_24;
                        r.flash_address = 24'(32'(table_base_24)
                                              + glyph_index * 32'(BYTES_24));
                    end
                    // a new glyph simply abandons whatever bytes were still due
                    glyph_origin_x  = pen_col;
                    draw_x          = pen_col;
                    draw_y          = pen_row;
                    glyph_bytes_due = r.fetch_length;
                    pen_col         = pen_col + (size_24 ? ADVANCE_24 : ADVANCE_32);
                end
                expected_draws.push_back(r);
            end
            CMD_FONT_BYTE:
            begin
                // stray bytes with no glyph active give nothing
                if (glyph_bytes_due != 0)
                begin
                    // row width follows the size setting in force now
                    row_width = size_24 ? WIDTH_24 : WIDTH_32;
                    hits      = 0;
                    for (int j = 0; j < 8; j++)
                    begin
                        if (it.font_byte[j])
                        begin
                            r              = '0;
                            r.kind         = KIND_PIXEL;
                            r.pixel_x      = draw_x;
                            r.pixel_y      = draw_y;
                            r.pixel_colour = ink;
                            expected_draws.push_back(r);
                            hits++;
                        end
                        draw_x = draw_x + 16'd1;
                        if (16'(draw_x - glyph_origin_x) == row_width)
                        begin
                            // end of row: the rest of the byte is dropped
                            draw_x = glyph_origin_x;
                            draw_y = draw_y + 16'd1;
                            break;
                        end
                    end
                    glyph_bytes_due = glyph_bytes_due - 8'd1;
                    if (hits > 0)
                        expected_draws[expected_draws.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
                // unused command, ignored
            end
        endcase
    endtask

    function automatic string show(input grb_result_t r);
        return $sformatf("kind=%0d addr=%06h len=%0d x=%04h y=%04h colour=%04h last=%0b",
                         r.kind, r.flash_address, r.fetch_length, r.pixel_x, r.pixel_y,
                         r.pixel_colour, r.last);
    endfunction

    // ------------------------------------------------------------------
    // monitor: checks results and predicts from accepted items, at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        grb_result_t got;
        grb_result_t want;
        in_item_t    seen;
        if (!rst_n)
        begin
            in_fire = 1'b0;
        end
        else
        begin
            in_fire = item_if.valid && item_if.ready;

            if (res_if.valid && res_if.ready)
            begin
                got.kind          = kind_t'(res_if.kind);
                got.flash_address = res_if.flash_address;
                got.fetch_length  = res_if.fetch_length;
                got.pixel_x       = res_if.pixel_x;
                got.pixel_y       = res_if.pixel_y;
                got.pixel_colour  = res_if.pixel_colour;
                got.last          = res_if.last;
                case (got.kind)
                    KIND_FETCH: fetch_seen++;
                    KIND_PIXEL: pixel_seen++;
                    default:    bad_seen++;
                endcase
                if (expected_draws.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with none expected, expected nothing, got %s",
                                 $time, show(got));
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: result mismatch, expected %s, got %s",
                                     $time, show(want), show(got));
                    end
                end
            end

            if (in_fire)
            begin
                seen.command   = item_if.command;
                seen.pen_x     = item_if.pen_x_in;
                seen.pen_y     = item_if.pen_y_in;
                seen.colour    = item_if.colour_in;
                seen.code_high = item_if.code_high;
                seen.code_low  = item_if.code_low;
                seen.font_byte = item_if.font_byte;
                items_taken++;
                render_item(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: offers queued items at the falling edge, with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!item_if.valid || in_fire)
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                item_if.valid <= 1'b0;
            end
            else if (feed_items.size() > 0)
            begin
                feed_next = feed_items.pop_front();
                item_if.valid     <= 1'b1;
                item_if.command   <= feed_next.command;
                item_if.pen_x_in  <= feed_next.pen_x;
                item_if.pen_y_in  <= feed_next.pen_y;
                item_if.colour_in <= feed_next.colour;
                item_if.code_high <= feed_next.code_high;
                item_if.code_low  <= feed_next.code_low;
                item_if.font_byte <= feed_next.font_byte;
                // gap before the next item, none when idling is switched off
                if (gaps_on && $urandom_range(99) >= 60)
                    feed_gap = pick_pause();
                else
                    feed_gap = 0;
            end
            else
            begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (burst_asked != burst_served)
        begin
            burst_served = burst_asked;
            sink_hold    = LONG_HOLD;
        end
        if (sink_hold > 0)
        begin
            sink_hold--;
            res_if.ready <= 1'b0;
        end
        else if (!gaps_on || $urandom_range(99) < 65)
        begin
            res_if.ready <= 1'b1;
        end
        else
        begin
            sink_hold = pick_pause() - 1;
            res_if.ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        if (idx == CFG_GLYPH_SIZE_MODE)
            size_24 = value[0];
        else if (idx == CFG_FONT_BASE_24)
            table_base_24 = value;
        reg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // wait until the sender is empty and every expected result has come
    task automatic wait_drained(input int settle);
        int waited;
        waited = 0;
        while ((feed_items.size() != 0 || item_if.valid === 1'b1
                || expected_draws.size() != 0) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
        begin
            errors++;
            $display("%0t: results did not drain, %0d still expected", $time,
                     expected_draws.size());
        end
        repeat (settle) @(posedge clk);
    endtask

    // an item of the given command with random contents in every other field
    function automatic in_item_t blank_item(input logic [1:0] cmd);
        in_item_t it;
        it.command   = cmd;
        it.pen_x     = 16'($urandom);
        it.pen_y     = 16'($urandom);
        it.colour    = 16'($urandom);
        it.code_high = 8'($urandom);
        it.code_low  = 8'($urandom);
        it.font_byte = 8'($urandom);
        return it;
    endfunction

    function automatic in_item_t pen_item(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] c);
        in_item_t it;
        it        = blank_item(CMD_SET_PEN);
        it.pen_x  = x;
        it.pen_y  = y;
        it.colour = c;
        return it;
    endfunction

    function automatic in_item_t char_item(input logic [7:0] hi, input logic [7:0] lo);
        in_item_t it;
        it           = blank_item(CMD_CHAR);
        it.code_high = hi;
        it.code_low  = lo;
        return it;
    endfunction

    function automatic in_item_t byte_item(input logic [7:0] b);
        in_item_t it;
        it           = blank_item(CMD_FONT_BYTE);
        it.font_byte = b;
        return it;
    endfunction

    // queue an item, counting separately those the block does something with
    task automatic push_item(input in_item_t it);
        case (it.command)
            CMD_SET_PEN:
                planned_work++;
            CMD_CHAR:
            begin
                planned_work++;
                if (it.code_high >= CODE_FIRST && it.code_low >= CODE_FIRST)
                    plan_bytes_left = size_24 ? int'(BYTES_24) : int'(BYTES_32);
            end
            CMD_FONT_BYTE:
            begin
                if (plan_bytes_left > 0)
                begin
                    planned_work++;
                    plan_bytes_left--;
                end
            end
            default:
            begin
            end
        endcase
        items_queued++;
        feed_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_pen();
        if ($urandom_range(99) < 25)
            return 16'($urandom_range(16'hFFFF, 16'hFFC0));
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] good_code();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return CODE_FIRST;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(8'hFF, CODE_FIRST));
    endfunction

    function automatic logic [7:0] rand_font_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        if (r < 30)
            return 8'h01 << $urandom_range(7);
        return 8'($urandom);
    endfunction

    // mostly short character sequences with random bitmaps, the rest noise
    task automatic queue_random(input int want);
        int target;
        int r;
        int n;
        target = items_queued + want;
        while (items_queued < target)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                push_item(pen_item(rand_pen(), rand_pen(), 16'($urandom)));
            end
            else if (r < 16)
            begin
                case ($urandom_range(3))
                    0: push_item(char_item(8'($urandom_range(8'hA0)), 8'($urandom)));
                    1: push_item(char_item(good_code(), 8'($urandom_range(8'hA0))));
                    2: push_item(blank_item(CMD_UNUSED));
                    default: push_item(byte_item(rand_font_byte()));
                endcase
            end
            else
            begin
                push_item(char_item(good_code(), good_code()));
                n = $urandom_range(1, 10);
                repeat (n) push_item(byte_item(rand_font_byte()));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [23:0] base_pick;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // 32x32 glyphs, font table at zero
        write_reg(CFG_GLYPH_SIZE_MODE, 24'd0);
        write_reg(CFG_FONT_BASE_24, 24'h000000);
        gaps_on = 1'b1;

        // pen near the top of the coordinate range so the glyph wraps
        push_item(pen_item(16'hFFF0, 16'hFFFF, 16'hFFFF));
        push_item(byte_item(8'hFF));                 // stray byte, no glyph yet
        push_item(blank_item(CMD_UNUSED));
        push_item(char_item(8'h00, 8'hA1));          // zone byte too low
        push_item(char_item(8'hFF, 8'hA0));          // position byte just too low
        push_item(char_item(CODE_FIRST, CODE_FIRST)); // first glyph of the table
        push_item(byte_item(8'hFF));
        push_item(byte_item(8'h00));                 // blank byte
        push_item(byte_item(8'h80));
        push_item(byte_item(8'h01));
        push_item(pen_item(16'h0000, 16'h0000, 16'h0000)); // pen moves mid-glyph
        push_item(byte_item(8'hAA));
        push_item(byte_item(8'h55));
        push_item(char_item(8'hFF, 8'hFF));          // last code, replaces the glyph
        push_item(byte_item(8'hFF));
        push_item(byte_item(8'h7E));
        wait_drained(SETTLE_CYCLES);

        // switch to 24x24 while that glyph is still open, table at the very top
        write_reg(CFG_GLYPH_SIZE_MODE, 24'd1);
        write_reg(CFG_FONT_BASE_24, 24'hFFFFFF);
        push_item(byte_item(8'hFF));
        push_item(byte_item(8'hFF));
        push_item(byte_item(8'hFF));
        push_item(pen_item(16'hFFFF, 16'hFFF8, 16'h8001));
        push_item(char_item(8'hFF, 8'hFF));          // address wraps at 24 bits
        push_item(byte_item(8'hFF));
        push_item(byte_item(8'h0F));
        push_item(char_item(CODE_FIRST, 8'h00));
        push_item(byte_item(8'hF0));

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_drained(SETTLE_CYCLES);
            base_pick = 24'($urandom);
            case (ph)
                0:
                begin
                    write_reg(CFG_GLYPH_SIZE_MODE, 24'd0);
                    write_reg(CFG_FONT_BASE_24, base_pick);
                end
                1:
                begin
                    write_reg(CFG_GLYPH_SIZE_MODE, 24'd1);
                    write_reg(CFG_FONT_BASE_24, base_pick);
                end
                2:
                begin
                    write_reg(CFG_FONT_BASE_24, 24'h000000);
                end
                3:
                begin
                    write_reg(CFG_GLYPH_SIZE_MODE, 24'd0);
                    write_reg(CFG_FONT_BASE_24, 24'hFFFFFF);
                end
                default:
                begin
                    write_reg(CFG_GLYPH_SIZE_MODE, 24'd1);
                end
            endcase

            // one phase runs with no idling at all on either side
            gaps_on = (ph != 2);

            // long receiver hold-off while the sender keeps offering items
            if (ph == 1)
            begin
                burst_asked++;
                // one whole 24x24 glyph followed by a couple of stray bytes
                push_item(char_item(good_code(), good_code()));
                repeat (int'(BYTES_24) + 2) push_item(byte_item(rand_font_byte()));
            end

            if (ph == 3)
            begin
                // sender pauses half way until everything owed has arrived
                queue_random(RANDOM_PER_PHASE / 2);
                wait_drained(0);
                queue_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
            end
            else
            begin
                queue_random(RANDOM_PER_PHASE);
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (expected_draws.size() != 0)
            errors++;

        $display("covered %0d accepted items (%0d acted on) over %0d register writes, both glyph sizes",
                 items_taken, planned_work, reg_writes);
        $display("compared %0d fetch requests, %0d pixel writes and %0d bad-code items",
                 fetch_seen, pixel_seen, bad_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
